@@ hw/rtl/scanline_seed_fill_engine_assert.svh @@
// Assertion macros for the scanline seed fill engine.
// Included by scanline_seed_fill_engine, which carries the concurrent checks; no dependencies.
`ifndef SCANLINE_SEED_FILL_ENGINE_ASSERT_SVH
`define SCANLINE_SEED_FILL_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SSF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define SSF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/ssf_pkg.sv @@
// Shared types, codes and defaults for the scanline seed fill engine.
// No dependencies.
`timescale 1ns / 1ps

package ssf_pkg;

	// Default geometry and storage
	localparam int IMAGE_WIDTH_DEF  = 128;
	localparam int IMAGE_HEIGHT_DEF = 128;
	localparam int STACK_DEPTH_DEF  = 1024;
	localparam int COLOR_BITS_DEF   = 24;

	// Fixed port field widths
	localparam int ACTION_W  = 2;
	localparam int COORD_W   = 7;
	localparam int PIXEL_W   = 24;
	localparam int STATUS_W  = 2;
	localparam int REG_IDX_W = 1;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 32;

	// Request actions
	localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_FILL  = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_RANGE    = 2'd2;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_BORDER = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_FILL   = 1'b1;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_WAIT,
		ST_POP,
		ST_POP_WAIT,
		ST_R_RD,
		ST_R_CHK,
		ST_L_RD,
		ST_L_CHK,
		ST_ROW,
		ST_A_RD,
		ST_A_CHK,
		ST_PUSH,
		ST_B_RD,
		ST_B_CHK,
		ST_B_END,
		ST_DONE
	} ssf_state_t;

	// Classification of one pixel against the configured colors
	typedef struct packed {
		logic is_border;
		logic is_open;
	} pix_class_t;

endpackage

@@ hw/rtl/ssf_ram.sv @@
// Single-port RAM with registered read data.
// Used for the frame buffer and the seed stack; no dependencies.
`timescale 1ns / 1ps

module ssf_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 24
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

@@ hw/rtl/ssf_pix_cmp.sv @@
// Shared pixel compare unit: checks one read-back pixel against border and fill.
// Depends on ssf_pkg.
`timescale 1ns / 1ps

module ssf_pix_cmp #(
	parameter int COLOR_BITS = 24
) (
	input  logic [COLOR_BITS-1:0] pixel,
	input  logic [COLOR_BITS-1:0] border,
	input  logic [COLOR_BITS-1:0] fill,
	output ssf_pkg::pix_class_t   cls
);
	import ssf_pkg::*;

	// Classify the pixel
	always_comb begin
		cls.is_border = (pixel == border);
		cls.is_open   = (pixel != border) && (pixel != fill);
	end

endmodule

@@ hw/rtl/scanline_seed_fill_engine.sv @@
// Scanline seed fill engine: frame buffer, seed stack and fill sequencer.
// A write goes straight to the result state; a read first waits for the registered read data.
// A fill visits each pixel by address, then registered read data of the single-port frame
// buffer, and pops its seeds from the seed stack; the block takes no new request until the
// result of the current one is in the output register.
// Depends on ssf_pkg, ssf_ram, ssf_pix_cmp and scanline_seed_fill_engine_assert.svh.
`timescale 1ns / 1ps
`include "scanline_seed_fill_engine_assert.svh"

module scanline_seed_fill_engine #(
	parameter int IMAGE_WIDTH  = ssf_pkg::IMAGE_WIDTH_DEF,
	parameter int IMAGE_HEIGHT = ssf_pkg::IMAGE_HEIGHT_DEF,
	parameter int STACK_DEPTH  = ssf_pkg::STACK_DEPTH_DEF,
	parameter int COLOR_BITS   = ssf_pkg::COLOR_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// request stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [ssf_pkg::IN_DATA_W-1:0]  s_tdata,  // x_coord[6:0], y_coord[13:7], pixel_in[37:14]
	input  logic [ssf_pkg::ACTION_W-1:0]   s_tuser,  // action[1:0]
	// result stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [ssf_pkg::OUT_DATA_W-1:0] m_tdata,  // pixel_out[23:0], status[25:24]
	// configuration writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ssf_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [ssf_pkg::PIXEL_W-1:0]    cfg_data
);
	import ssf_pkg::*;

	localparam int XW     = (IMAGE_WIDTH > 1) ? $clog2(IMAGE_WIDTH) : 1;
	localparam int YW     = (IMAGE_HEIGHT > 1) ? $clog2(IMAGE_HEIGHT) : 1;
	localparam int CW     = ((XW > YW) ? XW : YW) + 2;
	localparam int FB_DEP = IMAGE_WIDTH * IMAGE_HEIGHT;
	localparam int FB_AW  = $clog2(FB_DEP);
	localparam int SAW    = $clog2(STACK_DEPTH);
	localparam int SPW    = $clog2(STACK_DEPTH + 1);
	localparam int SEW    = XW + YW;

	localparam logic signed [CW-1:0] W_S = CW'(IMAGE_WIDTH);
	localparam logic signed [CW-1:0] H_S = CW'(IMAGE_HEIGHT);
	localparam logic [SPW-1:0]       SP_FULL = SPW'(STACK_DEPTH);

	function automatic logic signed [CW-1:0] ext_x(input logic [XW-1:0] v);
		return $signed({{(CW-XW){1'b0}}, v});
	endfunction

	function automatic logic signed [CW-1:0] ext_y(input logic [YW-1:0] v);
		return $signed({{(CW-YW){1'b0}}, v});
	endfunction

	function automatic logic [COLOR_BITS-1:0] to_color(input logic [PIXEL_W-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[COLOR_BITS-1:0];
	endfunction

	ssf_state_t state_q, state_d;

	logic [COLOR_BITS-1:0] border_q, fill_q;
	logic [SPW-1:0]        sp_q, sp_d;
	logic                  out_valid_q, out_valid_d;
	logic [PIXEL_W-1:0]    out_pix_q, out_pix_d;
	logic [STATUS_W-1:0]   out_stat_q, out_stat_d;
	logic [PIXEL_W-1:0]    res_pix_q, res_pix_d;
	logic [STATUS_W-1:0]   res_stat_q, res_stat_d;
	logic signed [CW-1:0]  cur_q, cur_d;
	logic signed [CW-1:0]  seed_x_q, seed_x_d;
	logic signed [CW-1:0]  seed_y_q, seed_y_d;
	logic signed [CW-1:0]  row_q, row_d;
	logic signed [CW-1:0]  xl_q, xl_d;
	logic signed [CW-1:0]  xr_q, xr_d;
	logic signed [CW-1:0]  start_q, start_d;
	logic                  found_q, found_d;
	logic                  dir_q, dir_d;

	// memory ports
	logic                  fb_we, fb_re;
	logic [FB_AW-1:0]      fb_addr;
	logic [COLOR_BITS-1:0] fb_wdata, fb_rdata;
	logic signed [CW-1:0]  col_sel, row_sel;
	logic                  stk_we, stk_re;
	logic [SAW-1:0]        stk_addr;
	logic [SEW-1:0]        stk_wdata, stk_rdata;

	// request decode
	logic [ACTION_W-1:0]   in_act;
	logic [31:0]           in_x32, in_y32;
	logic                  in_inside;
	logic signed [CW-1:0]  in_x, in_y;
	logic                  accept;
	logic signed [CW-1:0]  pop_x, pop_y, b_next;
	logic [31:0]           out_pix32;

	pix_class_t cls;

	assign in_act    = s_tuser;
	assign in_x32    = 32'(s_tdata[6:0]);
	assign in_y32    = 32'(s_tdata[13:7]);
	assign in_inside = (in_x32 < 32'(IMAGE_WIDTH)) && (in_y32 < 32'(IMAGE_HEIGHT));
	assign in_x      = $signed(in_x32[CW-1:0]);
	assign in_y      = $signed(in_y32[CW-1:0]);
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign pop_x     = ext_x(stk_rdata[XW-1:0]);
	assign pop_y     = ext_y(stk_rdata[SEW-1:XW]);
	assign b_next    = (cur_q == start_q) ? cur_q + CW'(1) : cur_q;

	// Frame buffer address from the selected column and row
	assign fb_addr = FB_AW'(row_sel[YW-1:0]) * FB_AW'(IMAGE_WIDTH)
		+ FB_AW'(col_sel[XW-1:0]);

	ssf_ram #(.DEPTH(FB_DEP), .WIDTH(COLOR_BITS)) u_fb (
		.clk   (clk),
		.we    (fb_we),
		.re    (fb_re),
		.addr  (fb_addr),
		.wdata (fb_wdata),
		.rdata (fb_rdata)
	);

	ssf_ram #(.DEPTH(STACK_DEPTH), .WIDTH(SEW)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.re    (stk_re),
		.addr  (stk_addr),
		.wdata (stk_wdata),
		.rdata (stk_rdata)
	);

	ssf_pix_cmp #(.COLOR_BITS(COLOR_BITS)) u_cmp (
		.pixel  (fb_rdata),
		.border (border_q),
		.fill   (fill_q),
		.cls    (cls)
	);

	// Next state, datapath updates and memory controls
	always_comb begin
		state_d     = state_q;
		sp_d        = sp_q;
		out_valid_d = out_valid_q;
		out_pix_d   = out_pix_q;
		out_stat_d  = out_stat_q;
		res_pix_d   = res_pix_q;
		res_stat_d  = res_stat_q;
		cur_d       = cur_q;
		seed_x_d    = seed_x_q;
		seed_y_d    = seed_y_q;
		row_d       = row_q;
		xl_d        = xl_q;
		xr_d        = xr_q;
		start_d     = start_q;
		found_d     = found_q;
		dir_d       = dir_q;
		fb_we       = 1'b0;
		fb_re       = 1'b0;
		fb_wdata    = fill_q;
		col_sel     = cur_q;
		row_sel     = row_q;
		stk_we      = 1'b0;
		stk_re      = 1'b0;
		stk_addr    = sp_q[SAW-1:0];
		stk_wdata   = {row_q[YW-1:0], cur_q[XW-1:0]};
		out_pix32   = 32'(fb_rdata);

		if (out_valid_q && m_tready) begin
			out_valid_d = 1'b0;
		end

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					res_pix_d  = '0;
					res_stat_d = STAT_OK;
					state_d    = ST_DONE;
					col_sel    = in_x;
					row_sel    = in_y;
					if (in_act != ACT_WRITE && in_act != ACT_READ && in_act != ACT_FILL) begin
						state_d = ST_DONE;
					end else if (!in_inside) begin
						res_stat_d = STAT_RANGE;
					end else if (in_act == ACT_WRITE) begin
						fb_we    = 1'b1;
						fb_wdata = to_color(s_tdata[37:14]);
					end else if (in_act == ACT_READ) begin
						fb_re   = 1'b1;
						state_d = ST_RD_WAIT;
					end else begin
						stk_we    = 1'b1;
						stk_addr  = '0;
						stk_wdata = {in_y[YW-1:0], in_x[XW-1:0]};
						sp_d      = SPW'(1);
						state_d   = ST_POP;
					end
				end
			end
			ST_RD_WAIT: begin
				out_pix32 = 32'(fb_rdata);
				res_pix_d = out_pix32[PIXEL_W-1:0];
				state_d   = ST_DONE;
			end
			ST_POP: begin
				if (sp_q == '0) begin
					state_d = ST_DONE;
				end else begin
					sp_d     = sp_q - SPW'(1);
					stk_re   = 1'b1;
					stk_addr = sp_d[SAW-1:0];
					state_d  = ST_POP_WAIT;
				end
			end
			ST_POP_WAIT: begin
				// paint the seed, then walk right
				seed_x_d = pop_x;
				seed_y_d = pop_y;
				col_sel  = pop_x;
				row_sel  = pop_y;
				fb_we    = 1'b1;
				cur_d    = pop_x + CW'(1);
				state_d  = ST_R_RD;
			end
			ST_R_RD: begin
				row_sel = seed_y_q;
				if (cur_q < W_S) begin
					fb_re   = 1'b1;
					state_d = ST_R_CHK;
				end else begin
					xr_d    = cur_q - CW'(1);
					cur_d   = seed_x_q - CW'(1);
					state_d = ST_L_RD;
				end
			end
			ST_R_CHK: begin
				row_sel = seed_y_q;
				if (!cls.is_border) begin
					fb_we   = 1'b1;
					cur_d   = cur_q + CW'(1);
					state_d = ST_R_RD;
				end else begin
					xr_d    = cur_q - CW'(1);
					cur_d   = seed_x_q - CW'(1);
					state_d = ST_L_RD;
				end
			end
			ST_L_RD: begin
				row_sel = seed_y_q;
				if (cur_q >= $signed(CW'(0))) begin
					fb_re   = 1'b1;
					state_d = ST_L_CHK;
				end else begin
					xl_d    = cur_q + CW'(1);
					dir_d   = 1'b0;
					state_d = ST_ROW;
				end
			end
			ST_L_CHK: begin
				row_sel = seed_y_q;
				if (!cls.is_border) begin
					fb_we   = 1'b1;
					cur_d   = cur_q - CW'(1);
					state_d = ST_L_RD;
				end else begin
					xl_d    = cur_q + CW'(1);
					dir_d   = 1'b0;
					state_d = ST_ROW;
				end
			end
			ST_ROW: begin
				// row below first, then row above
				if (!dir_q) begin
					if (seed_y_q + CW'(1) < H_S) begin
						row_d   = seed_y_q + CW'(1);
						cur_d   = xl_q;
						found_d = 1'b0;
						state_d = ST_A_RD;
					end else begin
						dir_d = 1'b1;
					end
				end else begin
					if (seed_y_q >= $signed(CW'(1))) begin
						row_d   = seed_y_q - CW'(1);
						cur_d   = xl_q;
						found_d = 1'b0;
						state_d = ST_A_RD;
					end else begin
						state_d = ST_POP;
					end
				end
			end
			ST_A_RD: begin
				if (cur_q <= xr_q) begin
					fb_re   = 1'b1;
					state_d = ST_A_CHK;
				end else begin
					state_d = ST_PUSH;
				end
			end
			ST_A_CHK: begin
				if (cls.is_open) begin
					found_d = 1'b1;
					cur_d   = cur_q + CW'(1);
					state_d = ST_A_RD;
				end else begin
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				// push the rightmost pixel of the open span
				start_d = cur_q;
				state_d = ST_B_RD;
				if (found_q) begin
					if (sp_q == SP_FULL) begin
						res_stat_d = STAT_OVERFLOW;
						sp_d       = '0;
						state_d    = ST_DONE;
					end else begin
						stk_we    = 1'b1;
						stk_wdata = {row_q[YW-1:0], cur_d[XW-1:0] - XW'(1)};
						sp_d      = sp_q + SPW'(1);
					end
				end
			end
			ST_B_RD: begin
				if (cur_q < xr_q) begin
					fb_re   = 1'b1;
					state_d = ST_B_CHK;
				end else begin
					state_d = ST_B_END;
				end
			end
			ST_B_CHK: begin
				if (!cls.is_open) begin
					cur_d   = cur_q + CW'(1);
					state_d = ST_B_RD;
				end else begin
					state_d = ST_B_END;
				end
			end
			ST_B_END: begin
				cur_d = b_next;
				if (b_next <= xr_q) begin
					found_d = 1'b0;
					state_d = ST_A_RD;
				end else if (!dir_q) begin
					dir_d   = 1'b1;
					state_d = ST_ROW;
				end else begin
					state_d = ST_POP;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					out_valid_d = 1'b1;
					out_pix_d   = res_pix_q;
					out_stat_d  = res_stat_q;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold the sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q        <= '0;
			out_valid_q <= 1'b0;
			border_q    <= to_color(24'h000000);
			fill_q      <= to_color(24'hFFFFFF);
		end else begin
			sp_q        <= sp_d;
			out_valid_q <= out_valid_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_BORDER: border_q <= to_color(cfg_data);
					REG_FILL:   fill_q   <= to_color(cfg_data);
				endcase
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		out_pix_q  <= out_pix_d;
		out_stat_q <= out_stat_d;
		res_pix_q  <= res_pix_d;
		res_stat_q <= res_stat_d;
		cur_q      <= cur_d;
		seed_x_q   <= seed_x_d;
		seed_y_q   <= seed_y_d;
		row_q      <= row_d;
		xl_q       <= xl_d;
		xr_q       <= xr_d;
		start_q    <= start_d;
		found_q    <= found_d;
		dir_q      <= dir_d;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W-PIXEL_W-STATUS_W){1'b0}}, out_stat_q, out_pix_q};

	// Checks
	`SSF_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, !s_tready,
		"block still ready after accepting a request")
	`SSF_ASSERT_NOW(a_sp_bound, clk, arst_n, 1'b1, sp_q <= SP_FULL,
		"seed stack pointer beyond depth")
	`SSF_ASSERT_NOW(a_idle_empty, clk, arst_n, state_q == ST_IDLE, sp_q == '0,
		"seed stack not empty between requests")
	`SSF_ASSERT_NOW(a_push_room, clk, arst_n, stk_we, sp_q < SP_FULL,
		"push onto a full seed stack")

endmodule
